// ===== rtl/sdoq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdoq_pkg: shared types and codes for the sorted date order queue
// Holds the command and status codes, the request and result payloads, the
// decoded job that travels from the front end to the back end, and the
// back-end state type.
// ----------------------------------------------------------------------------
package sdoq_pkg;

    localparam int SDOQ_DEPTH = 16;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int TAG_W   = 16;
    localparam int POS_W   = 5;
    localparam int FILL_W  = 5;

    // command codes on the request channel
    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_POP      = 3'd1;
    localparam logic [2:0] CMD_SET_TAG  = 3'd2;
    localparam logic [2:0] CMD_SET_DATE = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    // status codes on the result channel
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_BAD_POS = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [DAY_W-1:0]   due_day;
        logic [MONTH_W-1:0] due_month;
        logic [YEAR_W-1:0]  due_year;
        logic [TAG_W-1:0]   entry_tag;
        logic [POS_W-1:0]   position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [DAY_W-1:0]   out_day;
        logic [MONTH_W-1:0] out_month;
        logic [YEAR_W-1:0]  out_year;
        logic [TAG_W-1:0]   out_tag;
        logic [FILL_W-1:0]  fill;
    } t_out_item;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_POP,
        OP_SET_TAG,
        OP_SET_DATE,
        OP_READ,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op              op;
        t_entry           entry;
        logic [POS_W-1:0] pos;
    } t_job;

    // front end to job queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // job queue to back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

    typedef enum logic {
        BS_IDLE,
        BS_EXEC
    } t_bstate;

endpackage

// ===== rtl/sdoq_front.sv =====
// ----------------------------------------------------------------------------
// sdoq_front: request intake and decode
// Registers one request, decodes its command into a job and hands it to the
// job queue.
// ----------------------------------------------------------------------------
module sdoq_front
    import sdoq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    output logic     o_cmd_stall,
    input  t_in_item i_cmd,
    output t_push    o_push,
    input  logic     i_q_full
);

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic accept;
    logic push_done;

    assign o_cmd_stall = r_valid && i_q_full;
    assign accept      = i_cmd_valid && !o_cmd_stall;
    assign push_done   = r_valid && !i_q_full;

    always_comb begin
        n_job.entry.day   = i_cmd.due_day;
        n_job.entry.month = i_cmd.due_month;
        n_job.entry.year  = i_cmd.due_year;
        n_job.entry.tag   = i_cmd.entry_tag;
        n_job.pos         = i_cmd.position;
        unique case (i_cmd.cmd)
            CMD_INSERT:   n_job.op = OP_INSERT;
            CMD_POP:      n_job.op = OP_POP;
            CMD_SET_TAG:  n_job.op = OP_SET_TAG;
            CMD_SET_DATE: n_job.op = OP_SET_DATE;
            CMD_READ:     n_job.op = OP_READ;
            default:      n_job.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push_done) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

    assign o_push.valid = r_valid;
    assign o_push.job   = r_job;

endmodule

// ===== rtl/sdoq_queue.sv =====
// ----------------------------------------------------------------------------
// sdoq_queue: two-entry job queue
// Decouples the decode stage from the execute stage.
// ----------------------------------------------------------------------------
module sdoq_queue
    import sdoq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output t_head o_head,
    input  logic  i_pop
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_mem[r_rp];

endmodule

// ===== rtl/sdoq_back.sv =====
// ----------------------------------------------------------------------------
// sdoq_back: slot array and command execution
// Holds the ordered entries in a row of slot registers. Compares every
// slot's day against the job as it is loaded, then, once the output is free,
// inserts, shifts, edits or reads and loads the result register.
// ----------------------------------------------------------------------------
module sdoq_back
    import sdoq_pkg::*;
#(
    parameter int DEPTH = SDOQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_head     i_head,
    output logic      o_pop,
    output logic      o_res_valid,
    input  logic      i_res_stall,
    output t_out_item o_res
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

    t_bstate          r_state;
    t_bstate          n_state;
    t_entry           r_slot [DEPTH];
    t_entry           n_slot [DEPTH];
    t_entry           sh_up  [DEPTH];
    t_entry           sh_dn  [DEPTH];
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic [DEPTH-1:0] r_gt;
    logic [DEPTH-1:0] n_gt;
    logic [DEPTH-1:0] pre_le;
    logic [DEPTH-1:0] pre_lt;
    t_job             r_job;
    t_out_item        r_res;
    t_out_item        n_res;
    logic             r_res_valid;
    logic             out_free;
    logic             load;
    logic             fire;
    logic             any_gt;
    logic             full;
    logic             empty;
    logic             pos_ok;
    logic [CMP_W-1:0] pidx_w;
    logic [IDX_W-1:0] pidx;

    assign out_free = !r_res_valid || !i_res_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: if (i_head.valid) n_state = BS_EXEC;
            BS_EXEC: if (out_free)     n_state = BS_IDLE;
            default:                   n_state = BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        load = 1'b0;
        fire = 1'b0;
        unique case (r_state)
            BS_IDLE: load = i_head.valid;
            BS_EXEC: fire = out_free;
            default: begin
                load = 1'b0;
                fire = 1'b0;
            end
        endcase
    end

    assign o_pop = load;

    // day compare against every held slot
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_gt[k] = (OCC_W'(k) < r_occ) && (r_slot[k].day > i_head.job.entry.day);
        end
    end

    // insert point flags per slot: some greater day at or before / before it
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            pre_le[k] = |(r_gt << (DEPTH - 1 - k));
            pre_lt[k] = |(r_gt << (DEPTH - k));
        end
    end

    always_comb begin
        sh_up[0] = r_job.entry;
        for (int k = 1; k < DEPTH; k++) begin
            sh_up[k] = r_slot[k-1];
        end
        for (int k = 0; k < DEPTH - 1; k++) begin
            sh_dn[k] = r_slot[k+1];
        end
        sh_dn[DEPTH-1] = r_slot[DEPTH-1];
    end

    assign any_gt = |r_gt;
    assign full   = (r_occ == OCC_W'(DEPTH));
    assign empty  = (r_occ == '0);
    assign pidx_w = CMP_W'(r_job.pos) - CMP_W'(1);
    assign pidx   = pidx_w[IDX_W-1:0];
    assign pos_ok = (r_job.pos != '0) && (CMP_W'(r_job.pos) <= CMP_W'(r_occ));

    always_comb begin
        n_slot = r_slot;
        n_occ  = r_occ;
        n_res  = '0;
        n_res.status = ST_OK;
        unique case (r_job.op)
            OP_INSERT: begin
                if (full) begin
                    n_res.status = ST_FULL;
                end else begin
                    for (int k = 0; k < DEPTH; k++) begin
                        if (!any_gt) begin
                            if (OCC_W'(k) == r_occ) n_slot[k] = r_job.entry;
                        end else if (pre_lt[k]) begin
                            n_slot[k] = sh_up[k];
                        end else if (pre_le[k]) begin
                            n_slot[k] = r_job.entry;
                        end
                    end
                    n_occ = r_occ + OCC_W'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_slot          = sh_dn;
                    n_occ           = r_occ - OCC_W'(1);
                    n_res.out_day   = r_slot[0].day;
                    n_res.out_month = r_slot[0].month;
                    n_res.out_year  = r_slot[0].year;
                    n_res.out_tag   = r_slot[0].tag;
                end
            end
            OP_SET_TAG, OP_SET_DATE, OP_READ: begin
                if (!pos_ok) begin
                    n_res.status = ST_BAD_POS;
                end else if (r_job.op == OP_SET_TAG) begin
                    n_slot[pidx].tag = r_job.entry.tag;
                end else if (r_job.op == OP_SET_DATE) begin
                    n_slot[pidx].day   = r_job.entry.day;
                    n_slot[pidx].month = r_job.entry.month;
                    n_slot[pidx].year  = r_job.entry.year;
                end else begin
                    n_res.out_day   = r_slot[pidx].day;
                    n_res.out_month = r_slot[pidx].month;
                    n_res.out_year  = r_slot[pidx].year;
                    n_res.out_tag   = r_slot[pidx].tag;
                end
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
        n_res.fill = FILL_W'(n_occ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_occ       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_occ       <= n_occ;
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head.job;
            r_gt  <= n_gt;
        end
        if (fire) begin
            r_slot <= n_slot;
            r_res  <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/sorted_date_order_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_date_order_queue: bounded queue of dated orders kept sorted by day
// Request channel (i_cmd_valid / o_cmd_stall / i_cmd) takes one command per
// request: insert, pop front, set tag, set date or read at a 1-based
// position. Result channel (o_res_valid / i_res_stall / o_res) returns one
// result per request, in request order, with status, entry fields and fill.
//
// Path: a taken request passes the decode register, the job queue, the
// compare step and the execute step before its result is valid.
// The execute unit works on one job at a time: it compares every slot's
// day against the job, then shifts or edits the slot row and loads the
// result register, before it takes the next job.
//
// Reset clears the fill count, the job queue and the result valid flag; slot
// contents are not cleared, as only held entries are ever read.
// When the receiver stalls, hold the result in the output register; the
// execute unit loads and compares its next job and then waits, the two-entry
// job queue and the decode register keep taking requests, and o_cmd_stall
// rises once both are full.
// ----------------------------------------------------------------------------
module sorted_date_order_queue
    import sdoq_pkg::*;
#(
    parameter int DEPTH = SDOQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_stall,
    input  t_in_item  i_cmd,
    output logic      o_res_valid,
    input  logic      i_res_stall,
    output t_out_item o_res
);

    t_push push;
    t_head head;
    logic  q_full;
    logic  q_pop;

    // decode requests into jobs
    sdoq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_stall (o_cmd_stall),
        .i_cmd       (i_cmd),
        .o_push      (push),
        .i_q_full    (q_full)
    );

    // buffer jobs so decode and execute stall on their own
    sdoq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (q_pop)
    );

    // execute jobs against the slot row and drive results
    sdoq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

endmodule

// ===== tb/tb_sorted_date_order_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_date_order_queue: self-checking bench for the sorted date order queue
// Drive commands on the request channel and check every result against a
// day-sorted queue predictor kept in the bench. A short table of directed
// requests covers the empty, full and bad-position cases and field extremes.
// Random traffic follows in three idle/stall phases with fill/drain bias.
// ----------------------------------------------------------------------------
module tb_sorted_date_order_queue;
    import sdoq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QDEPTH         = SDOQ_DEPTH;
    localparam int          RAND_PER_PHASE = 367;
    localparam int          BIAS_RUN       = 40;
    localparam int          STALL_LIMIT    = 4000;
    localparam int          TAIL_CYCLES    = 20;
    // commands the block decodes as no-ops
    localparam logic [2:0]  CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI  = 3'd7;

    typedef struct {
        t_in_item  req;
        int        reps;
        bit        pinned;   // result typed into the table
        t_out_item res;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cmd_valid = 1'b0;
    logic      o_cmd_stall;
    t_in_item  i_cmd       = '0;
    logic      o_res_valid;
    logic      i_res_stall = 1'b0;
    t_out_item o_res;

    // predictor state: held entries in queue order and their count
    t_entry    slot_row [QDEPTH];
    int        slot_count    = 0;
    t_out_item due_results [$];
    t_dir_row  dir_rows [$];

    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    int        snd_idle_pct   = 6;
    int        rcv_stall_pct  = 53;
    bit        fill_bias      = 1'b1;

    sorted_date_order_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_stall (o_cmd_stall),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted request to the sorted queue and return
    // the result the block owes for it.
    // ------------------------------------------------------------------------
    function automatic t_out_item apply_order_cmd(t_in_item req);
        t_out_item res;
        int        at;
        res = '0;
        at  = 0;
        case (req.cmd)
            CMD_INSERT: begin
                if (slot_count >= QDEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // walk past every entry whose day is not greater, so equal
                    // days keep arrival order
                    while (at < slot_count && slot_row[at].day <= req.due_day)
                        at++;
                    for (int k = slot_count; k > at; k--)
                        slot_row[k] = slot_row[k-1];
                    slot_row[at].day   = req.due_day;
                    slot_row[at].month = req.due_month;
                    slot_row[at].year  = req.due_year;
                    slot_row[at].tag   = req.entry_tag;
                    slot_count++;
                    res.status = ST_OK;
                end
            end
            CMD_POP: begin
                if (slot_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status    = ST_OK;
                    res.out_day   = slot_row[0].day;
                    res.out_month = slot_row[0].month;
                    res.out_year  = slot_row[0].year;
                    res.out_tag   = slot_row[0].tag;
                    for (int k = 1; k < slot_count; k++)
                        slot_row[k-1] = slot_row[k];
                    slot_count--;
                end
            end
            CMD_SET_TAG, CMD_SET_DATE, CMD_READ: begin
                if (req.position == 0 || int'(req.position) > slot_count) begin
                    res.status = ST_BAD_POS;
                end else begin
                    at         = int'(req.position) - 1;
                    res.status = ST_OK;
                    if (req.cmd == CMD_SET_TAG) begin
                        slot_row[at].tag = req.entry_tag;
                    end else if (req.cmd == CMD_SET_DATE) begin
                        // edit in place, no re-sort
                        slot_row[at].day   = req.due_day;
                        slot_row[at].month = req.due_month;
                        slot_row[at].year  = req.due_year;
                    end else begin
                        res.out_day   = slot_row[at].day;
                        res.out_month = slot_row[at].month;
                        res.out_year  = slot_row[at].year;
                        res.out_tag   = slot_row[at].tag;
                    end
                end
            end
            default: res.status = ST_OK;
        endcase
        res.fill = FILL_W'(slot_count);
        return res;
    endfunction

    function automatic t_in_item make_cmd(logic [2:0] cmd, int day, int month, int year,
                                          int tag, int pos);
        t_in_item req;
        req.cmd       = cmd;
        req.due_day   = DAY_W'(day);
        req.due_month = MONTH_W'(month);
        req.due_year  = YEAR_W'(year);
        req.entry_tag = TAG_W'(tag);
        req.position  = POS_W'(pos);
        return req;
    endfunction

    function automatic t_out_item make_res(logic [1:0] status, int day, int month, int year,
                                           int tag, int fill);
        t_out_item res;
        res.status    = status;
        res.out_day   = DAY_W'(day);
        res.out_month = MONTH_W'(month);
        res.out_year  = YEAR_W'(year);
        res.out_tag   = TAG_W'(tag);
        res.fill      = FILL_W'(fill);
        return res;
    endfunction

    function automatic void add_row(t_in_item req, int reps, bit pinned, t_out_item res);
        t_dir_row row;
        row.req    = req;
        row.reps   = reps;
        row.pinned = pinned;
        row.res    = res;
        dir_rows.push_back(row);
    endfunction

    // Random request shaped by current fill: mostly valid positions, a bias
    // that alternates between filling and draining, a few no-op commands.
    function automatic t_in_item random_cmd();
        t_in_item req;
        int       r;
        int       ins_w;
        int       pop_w;
        ins_w = fill_bias ? 50 : 15;
        pop_w = fill_bias ? 15 : 50;
        r     = $urandom_range(0, 99);
        if (r < 3)
            req.cmd = 3'($urandom_range(32'(CMD_UNUSED_LO), 32'(CMD_UNUSED_HI)));
        else if (r < 3 + ins_w)
            req.cmd = CMD_INSERT;
        else if (r < 3 + ins_w + pop_w)
            req.cmd = CMD_POP;
        else begin
            case ($urandom_range(0, 2))
                0:       req.cmd = CMD_SET_TAG;
                1:       req.cmd = CMD_SET_DATE;
                default: req.cmd = CMD_READ;
            endcase
        end
        // keep days mostly in calendar range so the sort order is meaningful
        if ($urandom_range(0, 9) != 0)
            req.due_day = DAY_W'($urandom_range(1, 31));
        else
            req.due_day = DAY_W'($urandom);
        req.due_month = MONTH_W'($urandom);
        req.due_year  = YEAR_W'($urandom);
        req.entry_tag = TAG_W'($urandom);
        if (slot_count > 0 && $urandom_range(0, 99) < 80)
            req.position = POS_W'($urandom_range(1, slot_count));
        else
            req.position = POS_W'($urandom);
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Enter and leave at a falling edge; assign valid once
    // per step. Idle at random first, then hold the request until taken.
    // ------------------------------------------------------------------------
    task automatic send_request(t_in_item req, bit pinned, t_out_item fixed_res);
        t_out_item predicted;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_cmd_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd_valid <= 1'b1;
        i_cmd       <= req;
        do
            @(posedge i_clk);
        while (o_cmd_stall);
        predicted = apply_order_cmd(req);
        due_results.push_back(pinned ? fixed_res : predicted);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_pause();
        i_cmd_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (due_results.size() != 0);
    endtask

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // Receiver stall, changed at the falling edge only.
    always @(negedge i_clk) begin
        i_res_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end

    // Result checker: compare each taken result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (due_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing expected, expected none, got %h",
                         $time, o_res);
            end else begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_res.status));
                check_field("out_day", 32'(want.out_day), 32'(o_res.out_day));
                check_field("out_month", 32'(want.out_month), 32'(o_res.out_month));
                check_field("out_year", 32'(want.out_year), 32'(o_res.out_year));
                check_field("out_tag", 32'(want.out_tag), 32'(o_res.out_tag));
                check_field("fill", 32'(want.fill), 32'(o_res.fill));
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_cmd_valid && !o_cmd_stall) || (o_res_valid && !i_res_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int snd_pct_tab [3];
        int rcv_pct_tab [3];
        snd_pct_tab = '{6, 53, 0};
        rcv_pct_tab = '{53, 6, 0};

        // Directed table. Typed results stand where they follow at a glance;
        // zero-pinned rows fall back to the predictor.
        add_row(make_cmd(CMD_POP, 1, 1, 1, 0, 1), 1, 1'b1,
                make_res(ST_EMPTY, 0, 0, 0, 0, 0));
        add_row(make_cmd(CMD_READ, 1, 1, 1, 0, 1), 1, 1'b1,
                make_res(ST_BAD_POS, 0, 0, 0, 0, 0));
        add_row(make_cmd(CMD_SET_TAG, 1, 1, 1, 'hffff, 0), 1, 1'b1,
                make_res(ST_BAD_POS, 0, 0, 0, 0, 0));
        add_row(make_cmd(CMD_SET_DATE, 31, 15, 16383, 0, 31), 1, 1'b1,
                make_res(ST_BAD_POS, 0, 0, 0, 0, 0));
        add_row(make_cmd(CMD_UNUSED_LO, 0, 0, 0, 0, 0), 1, 1'b1,
                make_res(ST_OK, 0, 0, 0, 0, 0));
        add_row(make_cmd(CMD_UNUSED_HI, 31, 15, 16383, 'hffff, 31), 1, 1'b1,
                make_res(ST_OK, 0, 0, 0, 0, 0));
        // extremes of every field, stored without calendar checks
        add_row(make_cmd(CMD_INSERT, 31, 15, 16383, 'hffff, 31), 1, 1'b1,
                make_res(ST_OK, 0, 0, 0, 0, 1));
        add_row(make_cmd(CMD_INSERT, 0, 0, 0, 0, 0), 1, 1'b1,
                make_res(ST_OK, 0, 0, 0, 0, 2));
        // equal day lands behind the earlier one
        add_row(make_cmd(CMD_INSERT, 31, 12, 9999, 'h1234, 1), 1, 1'b1,
                make_res(ST_OK, 0, 0, 0, 0, 3));
        add_row(make_cmd(CMD_READ, 0, 0, 0, 0, 1), 1, 1'b1,
                make_res(ST_OK, 0, 0, 0, 0, 3));
        add_row(make_cmd(CMD_READ, 0, 0, 0, 0, 3), 1, 1'b1,
                make_res(ST_OK, 31, 12, 9999, 'h1234, 3));
        add_row(make_cmd(CMD_READ, 0, 0, 0, 0, 4), 1, 1'b1,
                make_res(ST_BAD_POS, 0, 0, 0, 0, 3));
        add_row(make_cmd(CMD_SET_TAG, 7, 7, 7, 'h5a5a, 2), 1, 1'b0, '0);
        // edited day is not re-sorted
        add_row(make_cmd(CMD_SET_DATE, 20, 6, 2024, 'h0bad, 1), 1, 1'b0, '0);
        add_row(make_cmd(CMD_INSERT, 10, 3, 1999, 'h00aa, 0), 1, 1'b0, '0);
        add_row(make_cmd(CMD_INSERT, 20, 9, 2001, 'h00bb, 0), 1, 1'b0, '0);
        add_row(make_cmd(CMD_READ, 0, 0, 0, 0, 2), 1, 1'b0, '0);
        // fill to the top, then refuse one more
        add_row(make_cmd(CMD_INSERT, 16, 8, 2010, 'hc3c3, 0), QDEPTH - 5, 1'b0, '0);
        add_row(make_cmd(CMD_INSERT, 1, 1, 1, 1, 1), 1, 1'b1,
                make_res(ST_FULL, 0, 0, 0, 0, QDEPTH));
        add_row(make_cmd(CMD_READ, 0, 0, 0, 0, QDEPTH), 1, 1'b0, '0);
        add_row(make_cmd(CMD_READ, 0, 0, 0, 0, QDEPTH + 1), 1, 1'b1,
                make_res(ST_BAD_POS, 0, 0, 0, 0, QDEPTH));
        add_row(make_cmd(CMD_POP, 0, 0, 0, 0, 0), QDEPTH, 1'b0, '0);
        add_row(make_cmd(CMD_POP, 0, 0, 0, 0, 0), 1, 1'b1,
                make_res(ST_EMPTY, 0, 0, 0, 0, 0));

        // hold reset, then release it at a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r])
            repeat (dir_rows[r].reps)
                send_request(dir_rows[r].req, dir_rows[r].pinned, dir_rows[r].res);

        // Random phases: sender idles little / receiver stalls a lot, then the
        // reverse, then full speed. Drain fully before each phase starts.
        for (int ph = 0; ph < 3; ph++) begin
            drain_pause();
            snd_idle_pct  = snd_pct_tab[ph];
            rcv_stall_pct = rcv_pct_tab[ph];
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % BIAS_RUN == 0)
                    fill_bias = ~fill_bias;
                if ($urandom_range(0, 199) == 0)
                    drain_pause();
                send_request(random_cmd(), 1'b0, '0);
            end
        end
        i_cmd_valid <= 1'b0;

        // wait for every owed result, then a short tail for stray outputs
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
